### rtl/core/wps_pkg.sv
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser package
// Shared word types, status codes and header constants for the parser.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int unsigned HdrLen = 36;
  localparam logic [31:0] TagData = 32'h6461_7461;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [3:0]         status;
    logic               last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_SAMPLE   = 4'd0,
    ST_RIFF     = 4'd1,
    ST_WAVE     = 4'd2,
    ST_FMT_ID   = 4'd3,
    ST_FMT_SIZE = 4'd4,
    ST_NOT_PCM  = 4'd5,
    ST_RATE     = 4'd6,
    ST_WIDTH    = 4'd7,
    ST_NO_TAG   = 4'd8,
    ST_EMPTY    = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SEARCH = 3'd1,
    PH_SIZE   = 3'd2,
    PH_DATA   = 3'd3,
    PH_IDLE   = 3'd4
  } phase_e;

  typedef enum logic [0:0] {
    REG_EXPECTED_RATE = 1'b0,
    REG_SEARCH_LIMIT  = 1'b1
  } reg_idx_e;

  // Which fixed header check a byte position belongs to, one bit per check
  // in file order: RIFF, WAVE, fmt id, fmt size, PCM format.
  typedef struct packed {
    logic [4:0] check;
    logic [7:0] value;
  } hdr_expect_t;

  function automatic hdr_expect_t hdr_expect(input logic [5:0] pos);
    hdr_expect_t e;
    e.check = 5'b00000;
    e.value = 8'h00;
    unique case (pos)
      6'd0:  begin e.check = 5'b00001; e.value = 8'h52; end
      6'd1:  begin e.check = 5'b00001; e.value = 8'h49; end
      6'd2:  begin e.check = 5'b00001; e.value = 8'h46; end
      6'd3:  begin e.check = 5'b00001; e.value = 8'h46; end
      6'd8:  begin e.check = 5'b00010; e.value = 8'h57; end
      6'd9:  begin e.check = 5'b00010; e.value = 8'h41; end
      6'd10: begin e.check = 5'b00010; e.value = 8'h56; end
      6'd11: begin e.check = 5'b00010; e.value = 8'h45; end
      6'd12: begin e.check = 5'b00100; e.value = 8'h66; end
      6'd13: begin e.check = 5'b00100; e.value = 8'h6d; end
      6'd14: begin e.check = 5'b00100; e.value = 8'h74; end
      6'd15: begin e.check = 5'b00100; e.value = 8'h20; end
      6'd16: begin e.check = 5'b01000; e.value = 8'h10; end
      6'd17: begin e.check = 5'b01000; e.value = 8'h00; end
      6'd18: begin e.check = 5'b01000; e.value = 8'h00; end
      6'd19: begin e.check = 5'b01000; e.value = 8'h00; end
      6'd20: begin e.check = 5'b10000; e.value = 8'h01; end
      6'd21: begin e.check = 5'b10000; e.value = 8'h00; end
      default: begin e.check = 5'b00000; e.value = 8'h00; end
    endcase
    return e;
  endfunction

endpackage

### rtl/core/wps_front.sv
// ----------------------------------------------------------------------------
// WAV parser front end
// Takes input words and holds them in a two-entry queue for the parser.
// ----------------------------------------------------------------------------
module wps_front import wps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  output logic     head_valid_o,
  output in_word_t head_word_o,
  input  logic     head_pop_i
);

  in_word_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  assign in_ready_o   = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_word_o  = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = head_pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

endmodule

### rtl/core/wps_back.sv
// ----------------------------------------------------------------------------
// WAV parser back end
// Parses header, tag search, data size and sample frames one word per cycle
// unless a result is stalled at the output, and drives the registered result.
// ----------------------------------------------------------------------------
module wps_back import wps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] expected_rate_i,
  input  logic [11:0] search_limit_i,
  input  logic        head_valid_i,
  input  in_word_t    head_word_i,
  output logic        head_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o
);

  phase_e      phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [4:0]  bad_q, bad_d;
  logic [31:0] rate_q, rate_d;
  logic        ch_one_q, ch_one_d;
  logic        bps_lo_ok_q, bps_lo_ok_d;
  logic        mono_q, mono_d;
  logic [31:0] window_q, window_d;
  logic [11:0] count_q, count_d;
  logic [31:0] remain_q, remain_d;
  logic [23:0] frame_q, frame_d;
  logic [1:0]  index_q, index_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_word_q, out_word_d;

  phase_e      phase_eff;
  logic [5:0]  pos_eff;
  logic [7:0]  b;
  hdr_expect_t exp_b;
  logic [4:0]  new_bad;
  logic [11:0] lim;
  logic [31:0] fsize;
  logic        emit;
  status_e     st;

  assign head_pop_o  = head_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign b         = head_word_i.data_byte;
  assign phase_eff = head_word_i.start_of_file ? PH_HEADER : phase_q;
  assign pos_eff   = head_word_i.start_of_file ? 6'd0 : pos_q;
  assign exp_b     = hdr_expect(pos_eff);
  assign new_bad   = (b != exp_b.value) ? exp_b.check : 5'b00000;
  assign lim       = (search_limit_i == 12'd0) ? 12'd1 : search_limit_i;
  assign fsize     = mono_q ? 32'd2 : 32'd4;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    bad_d       = bad_q;
    rate_d      = rate_q;
    ch_one_d    = ch_one_q;
    bps_lo_ok_d = bps_lo_ok_q;
    mono_d      = mono_q;
    window_d    = window_q;
    count_d     = count_q;
    remain_d    = remain_q;
    frame_d     = frame_q;
    index_d     = index_q;
    emit        = 1'b0;
    st          = ST_SAMPLE;
    out_word_d  = out_word_q;
    out_word_d.left_sample  = '0;
    out_word_d.right_sample = '0;
    out_word_d.last         = 1'b0;

    if (head_pop_o) begin
      unique case (phase_eff)
        PH_HEADER: begin
          // Field checks are folded in as each byte arrives; the verdict is
          // given on the final header byte in file order.
          bad_d = (pos_eff == 6'd0) ? new_bad : (bad_q | new_bad);
          if (pos_eff[5:2] == 4'd6) begin
            rate_d[{pos_eff[1:0], 3'b000} +: 8] = b;
          end
          if (pos_eff == 6'd22) begin
            ch_one_d = (b == 8'h01);
          end
          if (pos_eff == 6'd23) begin
            mono_d = ch_one_q && (b == 8'h00);
          end
          if (pos_eff == 6'd34) begin
            bps_lo_ok_d = (b[7:3] == 5'b00010);
          end
          if (pos_eff == 6'(HdrLen - 1)) begin
            pos_d = 6'd0;
            priority if (bad_q[0]) begin
              st = ST_RIFF;
            end else if (bad_q[1]) begin
              st = ST_WAVE;
            end else if (bad_q[2]) begin
              st = ST_FMT_ID;
            end else if (bad_q[3]) begin
              st = ST_FMT_SIZE;
            end else if (bad_q[4]) begin
              st = ST_NOT_PCM;
            end else if (rate_q != expected_rate_i) begin
              st = ST_RATE;
            end else if (!(bps_lo_ok_q && b == 8'h00)) begin
              st = ST_WIDTH;
            end else begin
              st = ST_SAMPLE;
            end
            if (st != ST_SAMPLE) begin
              emit    = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              window_d = '0;
              count_d  = '0;
              phase_d  = PH_SEARCH;
            end
          end else begin
            pos_d   = pos_eff + 6'd1;
            phase_d = PH_HEADER;
          end
        end
        PH_SEARCH: begin
          window_d = {window_q[23:0], b};
          count_d  = (count_q != 12'hFFF) ? count_q + 12'd1 : count_q;
          if (window_d == TagData) begin
            phase_d  = PH_SIZE;
            pos_d    = 6'd0;
            remain_d = '0;
          end else if (count_d >= lim) begin
            st      = ST_NO_TAG;
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_SIZE: begin
          remain_d[{pos_q[1:0], 3'b000} +: 8] = b;
          if (pos_q[1:0] == 2'd3) begin
            pos_d = 6'd0;
            if (remain_d < fsize) begin
              st      = ST_EMPTY;
              emit    = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              frame_d = '0;
              index_d = '0;
              phase_d = PH_DATA;
            end
          end else begin
            pos_d = pos_q + 6'd1;
          end
        end
        PH_DATA: begin
          remain_d = (remain_q != 32'd0) ? remain_q - 32'd1 : remain_q;
          if ({30'd0, index_q} + 32'd1 < fsize) begin
            frame_d[{index_q, 3'b000} +: 8] = b;
            index_d = index_q + 2'd1;
          end else begin
            if (mono_q) begin
              out_word_d.left_sample  = {b, frame_q[7:0]};
              out_word_d.right_sample = {b, frame_q[7:0]};
            end else begin
              out_word_d.left_sample  = frame_q[15:0];
              out_word_d.right_sample = {b, frame_q[23:16]};
            end
            out_word_d.last = (remain_d < fsize);
            frame_d = '0;
            index_d = '0;
            emit    = 1'b1;
            st      = ST_SAMPLE;
            if (remain_d < fsize) begin
              phase_d = PH_IDLE;
            end
          end
        end
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    out_word_d.status = st;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    if (!emit) begin
      out_word_d = out_word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      window_q    <= '0;
      count_q     <= '0;
      remain_q    <= '0;
      mono_q      <= 1'b0;
      frame_q     <= '0;
      index_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      window_q    <= window_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      mono_q      <= mono_d;
      frame_q     <= frame_d;
      index_q     <= index_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q       <= bad_d;
    rate_q      <= rate_d;
    ch_one_q    <= ch_one_d;
    bps_lo_ok_q <= bps_lo_ok_d;
    out_word_q  <= out_word_d;
  end

endmodule

### rtl/core/wav_pcm16_stream_parser_unit.sv
// A byte is stored in the input queue, then parsed, and its result word is registered.
// Throughput: one byte per cycle, set by the parser step, while the output is not stalled.
// While a result waits, the two-entry input queue takes up to two bytes before ready falls.
// Reset: asynchronous, active low; the parser returns to the header phase and the
// configuration registers return to a rate of 48000 and a search limit of 1000.
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser
// Parses a byte stream of WAV files into checked status words and 16-bit
// left/right sample pairs.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser_unit import wps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o
);

  logic [31:0] expected_rate_q;
  logic [11:0] search_limit_q;
  logic        head_valid;
  in_word_t    head_word;
  logic        head_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rate_q <= 32'd48000;
      search_limit_q  <= 12'd1000;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_EXPECTED_RATE: expected_rate_q <= cfg_wdata_i;
        REG_SEARCH_LIMIT:  search_limit_q  <= cfg_wdata_i[11:0];
        default:           expected_rate_q <= expected_rate_q;
      endcase
    end
  end

  wps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .head_valid_o (head_valid),
    .head_word_o  (head_word),
    .head_pop_i   (head_pop)
  );

  wps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .expected_rate_i (expected_rate_q),
    .search_limit_i  (search_limit_q),
    .head_valid_i    (head_valid),
    .head_word_i     (head_word),
    .head_pop_o      (head_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_word_o      (out_word_o)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser testbench
// Feeds whole WAV files byte by byte: a table of hand-made files, then random
// well-formed, damaged and noisy files under several register settings. Each
// result word is checked against a testbench parser model or a typed row's status.
// ----------------------------------------------------------------------------
module tb;
  import wps_pkg::*;

  localparam logic [31:0] RIFF_ID  = 32'h4646_4952;
  localparam logic [31:0] WAVE_ID  = 32'h4556_4157;
  localparam logic [31:0] FMT_ID   = 32'h2074_6d66;
  localparam logic [31:0] DEF_RATE = 32'd48000;
  localparam int          N_ROWS   = 22;
  localparam int          N_PHASES = 5;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam logic [7:0]  EXTREME_BYTES [8] =
    '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF};

  // One file to be sent: header fields, an optional corrupted header byte,
  // filler before the tag, the declared data size and how much is sent.
  typedef struct {
    bit          sof;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bps;
    int          poke_at;
    logic [7:0]  poke_val;
    int          junk;
    bit          tag;
    logic [31:0] dsize;
    int          payload;
    int          cut;
    int          noise;
    bit          typed;
    status_e     want;
  } wav_desc_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = REG_EXPECTED_RATE;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;

  bit          idle_on = 1'b0;
  int          stall_left = 0;
  int          quiet = 0;
  int          n_fail = 0;
  int          n_files = 0;
  int          n_bytes = 0;
  int          n_samples = 0;
  int          n_status = 0;

  out_word_t   due_words [$];

  // Parser model state and its copy of the registers.
  phase_e      ph;
  logic [7:0]  hdr [HdrLen];
  int          pos;
  logic [31:0] win;
  logic [11:0] scount;
  logic [31:0] remain;
  bit          mono;
  logic [23:0] fbytes;
  int          fidx;
  logic [31:0] rate_cfg = DEF_RATE;
  logic [11:0] limit_cfg = 12'd1000;

  wav_desc_t   dir_rows [N_ROWS];

  wav_pcm16_stream_parser_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] hdr_le32(input int off);
    return {hdr[off + 3], hdr[off + 2], hdr[off + 1], hdr[off]};
  endfunction

  function automatic logic [15:0] hdr_le16(input int off);
    return {hdr[off + 1], hdr[off]};
  endfunction

  function automatic status_e header_status();
    logic [15:0] bps;
    if (hdr_le32(0) != RIFF_ID) return ST_RIFF;
    if (hdr_le32(8) != WAVE_ID) return ST_WAVE;
    if (hdr_le32(12) != FMT_ID) return ST_FMT_ID;
    if (hdr_le32(16) != 32'd16) return ST_FMT_SIZE;
    if (hdr_le16(20) != 16'd1) return ST_NOT_PCM;
    if (hdr_le32(24) != rate_cfg) return ST_RATE;
    bps = hdr_le16(34);
    if (bps < 16'd16 || bps > 16'd23) return ST_WIDTH;
    return ST_SAMPLE;
  endfunction

  function automatic void clear_parser();
    ph = PH_HEADER;
    pos = 0;
    win = '0;
    scount = '0;
    remain = '0;
    mono = 1'b0;
    fbytes = '0;
    fidx = 0;
  endfunction

  // Advances the model by one byte; got is set when the byte yields a word.
  task automatic parse_byte(input logic [7:0] b, input logic sof, output bit got,
                            output out_word_t w);
    status_e     st;
    logic [11:0] lim;
    logic [15:0] lo;
    logic [15:0] hi;
    int          fsize;
    got = 1'b0;
    w = '0;
    if (sof) clear_parser();
    fsize = mono ? 2 : 4;
    case (ph)
      PH_HEADER: begin
        hdr[pos] = b;
        pos++;
        if (pos == HdrLen) begin
          pos = 0;
          st = header_status();
          if (st != ST_SAMPLE) begin
            ph = PH_IDLE;
            got = 1'b1;
            w.status = st;
          end else begin
            mono = (hdr_le16(22) == 16'd1);
            win = '0;
            scount = '0;
            ph = PH_SEARCH;
          end
        end
      end
      PH_SEARCH: begin
        win = {win[23:0], b};
        if (scount != 12'hFFF) scount++;
        if (win == TagData) begin
          ph = PH_SIZE;
          pos = 0;
          remain = '0;
        end else begin
          lim = (limit_cfg == '0) ? 12'd1 : limit_cfg;
          if (scount >= lim) begin
            ph = PH_IDLE;
            got = 1'b1;
            w.status = ST_NO_TAG;
          end
        end
      end
      PH_SIZE: begin
        remain |= 32'(b) << (8 * pos);
        pos++;
        if (pos == 4) begin
          pos = 0;
          if (remain < fsize) begin
            ph = PH_IDLE;
            got = 1'b1;
            w.status = ST_EMPTY;
          end else begin
            fbytes = '0;
            fidx = 0;
            ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (remain != '0) remain--;
        if (fidx + 1 < fsize) begin
          fbytes |= 24'(b) << (8 * fidx);
          fidx++;
        end else begin
          if (mono) begin
            lo = {b, fbytes[7:0]};
            hi = lo;
          end else begin
            lo = fbytes[15:0];
            hi = {b, fbytes[23:16]};
          end
          fbytes = '0;
          fidx = 0;
          got = 1'b1;
          w.left_sample = lo;
          w.right_sample = hi;
          w.status = ST_SAMPLE;
          w.last = (remain < fsize);
          if (w.last) ph = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  endtask

  // A typed row supplies its own expected status word instead of the model's.
  task automatic send_byte(input logic [7:0] b, input logic sof, input bit typed,
                           input status_e want);
    bit        got;
    out_word_t w;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{data_byte: b, start_of_file: sof};
    do @(posedge clk); while (!in_ready);
    parse_byte(b, sof, got, w);
    if (got) begin
      if (typed) begin
        w = '0;
        w.status = want;
      end
      due_words.push_back(w);
    end
    n_bytes++;
  endtask

  task automatic put_le(ref logic [7:0] q [$], input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) q.push_back(v[8 * k +: 8]);
  endtask

  task automatic send_file(input wav_desc_t d, input bit directed);
    logic [7:0] q [$];
    logic [7:0] b;
    if (d.noise > 0) begin
      repeat (d.noise) q.push_back(8'($urandom));
    end else begin
      put_le(q, RIFF_ID, 4);
      put_le(q, $urandom, 4);
      put_le(q, WAVE_ID, 4);
      put_le(q, FMT_ID, 4);
      put_le(q, 32'd16, 4);
      put_le(q, 32'd1, 2);
      put_le(q, {16'd0, d.chans}, 2);
      put_le(q, d.rate, 4);
      put_le(q, $urandom, 4);
      put_le(q, $urandom, 2);
      put_le(q, {16'd0, d.bps}, 2);
      if (d.poke_at >= 0) q[d.poke_at] = d.poke_val;
      for (int k = 0; k < d.junk; k++) begin
        // Directed filler never holds a 'd', so the tag cannot appear early.
        if (directed) b = 8'($urandom_range(0, 8'h60));
        else if ($urandom_range(0, 3) == 0) b = 8'("dat" >> (8 * $urandom_range(0, 2)));
        else b = 8'($urandom);
        q.push_back(b);
      end
      // The tag is sent in reading order, 'd' first.
      if (d.tag) begin
        for (int k = 3; k >= 0; k--) q.push_back(TagData[8 * k +: 8]);
      end
      put_le(q, d.dsize, 4);
      for (int k = 0; k < d.payload; k++)
        q.push_back(directed ? EXTREME_BYTES[k % 8] : 8'($urandom));
    end
    if (d.cut > 0) begin
      while (q.size() > d.cut) void'(q.pop_back());
    end
    foreach (q[k]) send_byte(q[k], d.sof && k == 0, d.typed, d.want);
    n_files++;
  endtask

  task automatic random_desc(output wav_desc_t d);
    int r;
    int lim_eff;
    lim_eff = (limit_cfg == '0) ? 1 : int'(limit_cfg);
    r = $urandom_range(0, 99);
    d = '{sof: 1'b1, chans: 16'd2, rate: rate_cfg, bps: 16'($urandom_range(16, 23)),
          poke_at: -1, poke_val: 8'h00, junk: 0, tag: 1'b1, dsize: '0, payload: 0,
          cut: 0, noise: 0, typed: 1'b0, want: ST_SAMPLE};
    case ($urandom_range(0, 4))
      0, 1: d.chans = 16'd1;
      2, 3: d.chans = 16'd2;
      default: d.chans = 16'($urandom);
    endcase
    if (lim_eff >= 4) d.junk = $urandom_range(0, (lim_eff - 4 < 10) ? lim_eff - 4 : 10);
    else d.junk = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      // Huge declared size: the file is cut short by the next start of file.
      d.dsize = $urandom;
      d.payload = $urandom_range(0, 30);
    end else begin
      d.dsize = $urandom_range(0, 24);
      if ($urandom_range(0, 3) != 0) d.payload = int'(d.dsize) + $urandom_range(0, 3);
      else d.payload = $urandom_range(0, d.dsize);
    end
    if (r >= 93) begin
      d.noise = $urandom_range(1, 60);
    end else if (r >= 87) begin
      d.tag = 1'b0;
      d.junk = (lim_eff <= 64) ? lim_eff + $urandom_range(0, 3) : $urandom_range(4, 20);
    end else if (r >= 80) begin
      if ($urandom_range(0, 1) == 0) d.rate = $urandom;
      else d.bps = 16'($urandom);
    end else if (r >= 65) begin
      d.poke_at = $urandom_range(0, HdrLen - 1);
      d.poke_val = 8'($urandom);
    end
    if ($urandom_range(0, 9) == 0) d.cut = $urandom_range(1, 70);
  endtask

  // Registers change only once every owed word has arrived and the pipeline
  // has had time to swallow bytes that yield nothing.
  task automatic write_regs(input logic [31:0] rate, input logic [11:0] lim);
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_EXPECTED_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_idx <= REG_SEARCH_LIMIT;
    cfg_wdata <= {20'd0, lim};
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_cfg = rate;
    limit_cfg = lim;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 19);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] expv,
                             input logic signed [31:0] gotv);
    if (gotv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, gotv);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (out_word.status == ST_SAMPLE) n_samples++;
      else n_status++;
      if (due_words.size() == 0) begin
        $error("unexpected word: status %0d, left %0d, right %0d", out_word.status,
               out_word.left_sample, out_word.right_sample);
        n_fail++;
      end else begin
        w = due_words.pop_front();
        check_field("left_sample", w.left_sample, out_word.left_sample);
        check_field("right_sample", w.right_sample, out_word.right_sample);
        check_field("status", w.status, out_word.status);
        check_field("last", w.last, out_word.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    wav_desc_t d;
    int        phase_bytes;
    int        phase_files;
    // Columns: sof, channels, rate, bits per sample, poked byte and value, filler,
    // tag, declared size, payload, cut, noise, typed, expected status.
    dir_rows = '{
      // Bytes before any start of file are parsed as a header.
      '{1'b0, 16'd2, DEF_RATE, 16'd16, -1, 8'h00, 2, 1'b1, 32'd8, 8, 0, 0, 1'b0, ST_SAMPLE},
      '{1'b1, 16'd2, DEF_RATE, 16'd16, 0, 8'h58, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1, ST_RIFF},
      '{1'b1, 16'd2, DEF_RATE, 16'd16, 11, 8'h00, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1, ST_WAVE},
      '{1'b1, 16'd2, DEF_RATE, 16'd16, 15, 8'h00, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1, ST_FMT_ID},
      '{1'b1, 16'd2, DEF_RATE, 16'd16, 16, 8'h12, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1,
        ST_FMT_SIZE},
      '{1'b1, 16'd2, DEF_RATE, 16'd16, 20, 8'h03, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1,
        ST_NOT_PCM},
      '{1'b1, 16'd2, 32'd44100, 16'd16, -1, 8'h00, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1, ST_RATE},
      '{1'b1, 16'd2, DEF_RATE, 16'd15, -1, 8'h00, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1, ST_WIDTH},
      '{1'b1, 16'd2, DEF_RATE, 16'd24, -1, 8'h00, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1, ST_WIDTH},
      '{1'b1, 16'd2, DEF_RATE, 16'h8010, -1, 8'h00, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1, ST_WIDTH},
      // Several checks fail at once: the first in file order wins.
      '{1'b1, 16'd2, 32'd44100, 16'd8, 8, 8'h00, 0, 1'b1, 32'd8, 8, 36, 0, 1'b1, ST_WAVE},
      '{1'b1, 16'd1, DEF_RATE, 16'd23, -1, 8'h00, 3, 1'b1, 32'd8, 8, 0, 0, 1'b0, ST_SAMPLE},
      '{1'b1, 16'd1, DEF_RATE, 16'd16, -1, 8'h00, 0, 1'b1, 32'd1, 2, 0, 0, 1'b1, ST_EMPTY},
      '{1'b1, 16'd2, DEF_RATE, 16'd16, -1, 8'h00, 0, 1'b1, 32'd3, 4, 0, 0, 1'b1, ST_EMPTY},
      '{1'b1, 16'd2, DEF_RATE, 16'd16, -1, 8'h00, 0, 1'b1, 32'd0, 0, 0, 0, 1'b1, ST_EMPTY},
      // Trailing partial frame is dropped and later bytes are ignored.
      '{1'b1, 16'd2, DEF_RATE, 16'd16, -1, 8'h00, 5, 1'b1, 32'd10, 13, 0, 0, 1'b0, ST_SAMPLE},
      '{1'b1, 16'd1, DEF_RATE, 16'd16, -1, 8'h00, 0, 1'b1, 32'd7, 8, 0, 0, 1'b0, ST_SAMPLE},
      // Files cut short in the header and in the data, restarted by the next row.
      '{1'b1, 16'd2, DEF_RATE, 16'd16, -1, 8'h00, 0, 1'b1, 32'd8, 8, 20, 0, 1'b0, ST_SAMPLE},
      '{1'b1, 16'd2, DEF_RATE, 16'd16, -1, 8'h00, 0, 1'b1, 32'd16, 16, 50, 0, 1'b0, ST_SAMPLE},
      '{1'b1, 16'd1, DEF_RATE, 16'd16, -1, 8'h00, 0, 1'b1, 32'hFFFF_FFFF, 8, 0, 0, 1'b0,
        ST_SAMPLE},
      '{1'b1, 16'd0, DEF_RATE, 16'd16, -1, 8'h00, 0, 1'b1, 32'd4, 4, 0, 0, 1'b0, ST_SAMPLE},
      '{1'b1, 16'hFFFF, DEF_RATE, 16'd16, -1, 8'h00, 0, 1'b1, 32'd8, 8, 0, 0, 1'b0, ST_SAMPLE}
    };
    clear_parser();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      send_file(dir_rows[i], 1'b1);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: write_regs(32'd44100, 12'd4095);
        1: write_regs(32'd0, 12'd1);
        2: write_regs(32'hFFFF_FFFF, 12'd0);
        3: write_regs($urandom, 12'($urandom_range(4, 40)));
        default: write_regs(32'd22050, 12'd64);
      endcase
      phase_bytes = n_bytes;
      phase_files = 0;
      while (n_bytes - phase_bytes < 30 || phase_files < 1) begin
        idle_on <= (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
        random_desc(d);
        send_file(d, 1'b0);
        phase_files++;
      end
    end

    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("summary: %0d files, %0d bytes, %0d register settings after reset",
             n_files, n_bytes, N_PHASES);
    $display("summary: %0d sample words and %0d status words compared", n_samples,
             n_status);
    if (n_fail == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
rtl/core/wps_pkg.sv
rtl/core/wps_front.sv
rtl/core/wps_back.sv
rtl/core/wav_pcm16_stream_parser_unit.sv
tb/tb.sv
